FILE: sv/spsfd_pkg.sv
// shared types, constants and helpers of the stereo pitch-shift feedback delay
package spsfd_pkg;

    localparam int SAMPLE_W            = 24;
    localparam int DECAY_W             = 16;
    localparam int MIX_W               = 17;
    localparam int STEP_W              = 18;
    localparam int FRAC_W              = 16;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 18;
    localparam int DEFAULT_DELAY_DEPTH = 65536;
    localparam int SAT_IN_W            = 28;

    localparam logic [MIX_W-1:0] MIX_ONE = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIX_LEVEL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic {
        ST_READ,
        ST_WRITE
    } t_state;

    localparam logic signed [SAT_IN_W-1:0] SAT_MAX = 28'sd8388607;
    localparam logic signed [SAT_IN_W-1:0] SAT_MIN = -28'sd8388608;

    function automatic t_sample sat24(input logic signed [SAT_IN_W-1:0] v);
        t_sample r;
        if (v > SAT_MAX) begin
            r = SAT_MAX[SAMPLE_W-1:0];
        end else if (v < SAT_MIN) begin
            r = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/spsfd_ram.sv
// generic single-port synchronous ram with registered read
module spsfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

FILE: sv/spsfd_chan.sv
// per-channel feedback and dry/wet crossfade arithmetic
module spsfd_chan (
    input  spsfd_pkg::t_sample                 i_wet,
    input  spsfd_pkg::t_sample                 i_dry,
    input  logic [spsfd_pkg::DECAY_W-1:0]      i_decay,
    input  logic [spsfd_pkg::MIX_W-1:0]        i_mix,
    output spsfd_pkg::t_sample                 o_store,
    output spsfd_pkg::t_sample                 o_out
);

    logic signed [40:0]                   fb_prod;
    logic signed [24:0]                   fb;
    logic signed [spsfd_pkg::SAT_IN_W-1:0] store_sum;
    logic [spsfd_pkg::MIX_W-1:0]          mix_c;
    logic signed [24:0]                   diff;
    logic signed [42:0]                   mix_prod;
    logic signed [26:0]                   mix_q;
    logic signed [spsfd_pkg::SAT_IN_W-1:0] out_sum;

    assign fb_prod   = i_wet * $signed({1'b0, i_decay});
    assign fb        = fb_prod[40:16];
    assign store_sum = $signed({{4{i_dry[23]}}, i_dry}) + $signed({{3{fb[24]}}, fb});
    assign o_store   = spsfd_pkg::sat24(store_sum);

    // dry*(1-m) + wet*m folded into dry + (wet-dry)*m
    assign mix_c    = (i_mix > spsfd_pkg::MIX_ONE) ? spsfd_pkg::MIX_ONE : i_mix;
    assign diff     = $signed({i_wet[23], i_wet}) - $signed({i_dry[23], i_dry});
    assign mix_prod = diff * $signed({1'b0, mix_c});
    assign mix_q    = mix_prod[42:16];
    assign out_sum  = $signed({{4{i_dry[23]}}, i_dry}) + $signed({mix_q[26], mix_q});
    assign o_out    = spsfd_pkg::sat24(out_sum);

endmodule

FILE: sv/stereo_pitch_shift_feedback_delay.sv
// top level of the stereo pitch-shifted feedback delay
//
// input channel: i_in_valid / o_in_stall with i_left_in, i_right_in, one stereo pair
// per request. output channel: o_out_valid / i_out_stall with o_left_out, o_right_out.
// config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data; index 0
// decay gain, 1 mix level, 2 phase step, other indexes ignored. o_cfg_ready is high.
// each request takes a delay ram read of the tap in the read state, then a write of the
// feedback sum in the write state, on the single port of each channel's delay ram.
// a new request is not taken until the write of the last one has run.
// the result is computed in the write state and pushed into the output queue at its
// end; o_out_valid is high while the queue holds a result.
// a 2-entry output queue holds results while the receiver stalls; the input side
// stalls while the write cycle runs or when the queue is full.
// reset clears pointer, phase, registers and queue; no ram clearing pass runs:
// a fill mark makes entries not yet written since reset read as zero.
module stereo_pitch_shift_feedback_delay #(
    parameter int DELAY_DEPTH = spsfd_pkg::DEFAULT_DELAY_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  spsfd_pkg::t_sample                   i_left_in,
    input  spsfd_pkg::t_sample                   i_right_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output spsfd_pkg::t_sample                   o_left_out,
    output spsfd_pkg::t_sample                   o_right_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [spsfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [spsfd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int PW = AW + spsfd_pkg::FRAC_W;
    localparam logic [AW:0]          DEPTH_EXT = (AW+1)'(DELAY_DEPTH);
    localparam logic [AW-1:0]        WP_LAST   = AW'(DELAY_DEPTH - 1);
    localparam logic signed [PW+1:0] SPAN      = (PW+2)'(DELAY_DEPTH) << spsfd_pkg::FRAC_W;

    spsfd_pkg::t_state                 r_state, n_state;
    logic [AW-1:0]                     r_wp;
    logic [PW-1:0]                     r_phase;
    logic                              r_full;
    logic                              r_rd_ok;
    logic [spsfd_pkg::DECAY_W-1:0]     r_decay;
    logic [spsfd_pkg::MIX_W-1:0]       r_mix;
    logic signed [spsfd_pkg::STEP_W-1:0] r_step;
    spsfd_pkg::t_sample                r_dry_l, r_dry_r;
    logic [1:0]                        r_cnt, n_cnt;
    spsfd_pkg::t_sample                r_q0_l, r_q0_r, r_q1_l, r_q1_r;
    spsfd_pkg::t_sample                n_q0_l, n_q0_r, n_q1_l, n_q1_r;

    logic                              in_acc, push, pop;
    logic [AW:0]                       ra_sum;
    logic [AW-1:0]                     ra, ram_addr;
    logic                              ram_we;
    logic signed [PW+1:0]              ph_sum, ph_next;
    spsfd_pkg::t_sample                rd_l, rd_r, wet_l, wet_r;
    spsfd_pkg::t_sample                st_l, st_r, out_l, out_r;
    logic [1:0]                        slot;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state == spsfd_pkg::ST_WRITE) || (r_cnt == 2'd2);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign push        = (r_state == spsfd_pkg::ST_WRITE);
    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_left_out  = r_q0_l;
    assign o_right_out = r_q0_r;

    // tap address: pointer plus integer phase, mod depth
    assign ra_sum   = {1'b0, r_wp} + {1'b0, r_phase[PW-1:spsfd_pkg::FRAC_W]};
    assign ra       = (ra_sum >= DEPTH_EXT) ? AW'(ra_sum - DEPTH_EXT) : ra_sum[AW-1:0];
    assign ram_addr = push ? r_wp : ra;
    assign ram_we   = push;

    assign ph_sum = $signed({2'b00, r_phase})
                  + $signed({{(PW+2-spsfd_pkg::STEP_W){r_step[spsfd_pkg::STEP_W-1]}}, r_step});

    always_comb begin
        ph_next = ph_sum;
        if (ph_sum >= SPAN) begin
            ph_next = ph_sum - SPAN;
        end else if (ph_sum[PW+1]) begin
            ph_next = ph_sum + SPAN;
        end
    end

    spsfd_ram #(.WIDTH(spsfd_pkg::SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (st_l),
        .o_rdata (rd_l)
    );

    spsfd_ram #(.WIDTH(spsfd_pkg::SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (st_r),
        .o_rdata (rd_r)
    );

    // entries beyond the fill mark were never written since reset
    assign wet_l = r_rd_ok ? rd_l : '0;
    assign wet_r = r_rd_ok ? rd_r : '0;

    spsfd_chan u_chan_l (
        .i_wet   (wet_l),
        .i_dry   (r_dry_l),
        .i_decay (r_decay),
        .i_mix   (r_mix),
        .o_store (st_l),
        .o_out   (out_l)
    );

    spsfd_chan u_chan_r (
        .i_wet   (wet_r),
        .i_dry   (r_dry_r),
        .i_decay (r_decay),
        .i_mix   (r_mix),
        .o_store (st_r),
        .o_out   (out_r)
    );

    always_comb begin
        n_state = spsfd_pkg::ST_READ;
        case (r_state)
            spsfd_pkg::ST_READ: begin
                if (in_acc) begin
                    n_state = spsfd_pkg::ST_WRITE;
                end
            end
            spsfd_pkg::ST_WRITE: begin
                n_state = spsfd_pkg::ST_READ;
            end
            default: begin
                n_state = spsfd_pkg::ST_READ;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spsfd_pkg::ST_READ;
        end else begin
            r_state <= n_state;
        end
    end

    // output queue
    always_comb begin
        n_q0_l = r_q0_l;
        n_q0_r = r_q0_r;
        n_q1_l = r_q1_l;
        n_q1_r = r_q1_r;
        slot   = r_cnt - {1'b0, pop};
        if (pop) begin
            n_q0_l = r_q1_l;
            n_q0_r = r_q1_r;
        end
        if (push) begin
            if (slot == 2'd0) begin
                n_q0_l = out_l;
                n_q0_r = out_r;
            end else begin
                n_q1_l = out_l;
                n_q1_r = out_r;
            end
        end
        n_cnt = slot + {1'b0, push};
    end

    always_ff @(posedge i_clk) begin
        r_q0_l <= n_q0_l;
        r_q0_r <= n_q0_r;
        r_q1_l <= n_q1_l;
        r_q1_r <= n_q1_r;
        if (in_acc) begin
            r_dry_l <= i_left_in;
            r_dry_r <= i_right_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_wp    <= '0;
            r_phase <= '0;
            r_full  <= 1'b0;
            r_rd_ok <= 1'b0;
            r_decay <= '0;
            r_mix   <= '0;
            r_step  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (in_acc) begin
                r_rd_ok <= r_full || (ra < r_wp);
            end
            if (push) begin
                r_phase <= ph_next[PW-1:0];
                if (r_wp == WP_LAST) begin
                    r_wp   <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    spsfd_pkg::CFG_DECAY_GAIN: r_decay <= i_cfg_data[spsfd_pkg::DECAY_W-1:0];
                    spsfd_pkg::CFG_MIX_LEVEL:  r_mix   <= i_cfg_data[spsfd_pkg::MIX_W-1:0];
                    spsfd_pkg::CFG_PHASE_STEP: r_step  <= $signed(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

FILE: sv/spsfd_checker.sv
// port-level assertion checker for the stereo pitch-shifted feedback delay, with bind
module spsfd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input spsfd_pkg::t_sample               i_left_in,
    input spsfd_pkg::t_sample               i_right_in,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input spsfd_pkg::t_sample               o_left_out,
    input spsfd_pkg::t_sample               o_right_out
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_left_out) && $stable(o_right_out))
        else $error("stalled result changed or dropped");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=>
            i_in_valid && $stable(i_left_in) && $stable(i_right_in))
        else $error("stalled request changed or dropped");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted during write cycle");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 o_out_valid)
        else $error("no result two cycles after request");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind stereo_pitch_shift_feedback_delay spsfd_checker u_spsfd_checker (.*);
